// File: hw/rtl/pdq_pkg.sv
// Package for the packet delay queue: sizes, codes, payload structs and
// small helper functions. Used by pdq_mod_unit and packet_delay_queue.
`default_nettype none

package pdq_pkg;

  localparam int CAPACITY    = 2048;
  localparam int PTR_W       = $clog2(CAPACITY);
  localparam int CNT_W       = 12;
  localparam int HANDLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int DLY_W       = 14;
  localparam int BATCH_W     = 12;
  localparam int LFSR_W      = 16;
  localparam int STEP_W      = $clog2(LFSR_W);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DLY_W-1:0]   DELAY_LIMIT   = DLY_W'(15000);
  localparam logic [DLY_W-1:0]   DELAY_DEFAULT = DLY_W'(50);
  localparam logic [BATCH_W-1:0] BATCH_DEFAULT = BATCH_W'(800);
  localparam logic [LFSR_W-1:0]  LFSR_TAPS     = 16'hB400;
  localparam logic [LFSR_W-1:0]  SEED_DEFAULT  = LFSR_W'(1);

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_POLL   = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_PASS  = 3'd1,
    KIND_DUE   = 3'd2,
    KIND_FLUSH = 3'd3,
    KIND_DRAIN = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAG_INBOUND  = 3'd0,
    REG_LAG_OUTBOUND = 3'd1,
    REG_FIXED_DELAY  = 3'd2,
    REG_RANGE_ENABLE = 3'd3,
    REG_RANGE_MIN    = 3'd4,
    REG_RANGE_MAX    = 3'd5,
    REG_FLUSH_BATCH  = 3'd6,
    REG_RANDOM_SEED  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MOD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [HANDLE_BITS-1:0] packet_handle;
    logic                   is_outbound;
    logic [TIME_W-1:0]      now_ms;
  } in_req_t;

  typedef struct packed {
    logic [2:0]             result_kind;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   out_outbound;
    logic                   buffer_nonempty;
    logic [CNT_W-1:0]       buffer_count;
  } out_res_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic                   outbound;
    logic [TIME_W-1:0]      due;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [DLY_W-1:0]  divisor;
  } mod_req_t;

  function automatic logic [DLY_W-1:0] clamp_delay(input logic [DLY_W-1:0] v);
    return (v > DELAY_LIMIT) ? DELAY_LIMIT : v;
  endfunction

  // Galois LFSR, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pdq_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle, over all LFSR_W dividend bits.
// Depends on pdq_pkg for widths and the request struct.
`default_nettype none

module pdq_mod_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire pdq_pkg::mod_req_t       req,
  output logic                         done,
  output logic [pdq_pkg::DLY_W-1:0]    rem
);
  import pdq_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [LFSR_W-1:0] dvd_r;
  logic [DLY_W-1:0]  div_r;
  logic [DLY_W-1:0]  rem_r;
  logic [DLY_W-1:0]  rem_nxt;
  logic [DLY_W:0]    trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[LFSR_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = DLY_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[DLY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(LFSR_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[LFSR_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/packet_delay_queue.sv
// Packet delay queue: an arrival with a random delay draw runs ST_MOD (the
// remainder unit) then ST_FINISH; poll and close run ST_FETCH then
// ST_FINISH, others ST_FINISH only. busy is high until the result is set
// up, so one item is in work at a time. The result strobe lasts one cycle
// and cannot be held off. Synchronous reset clears pointers, count and flush
// state and restores register defaults; held entries are not cleared.
`default_nettype none

module packet_delay_queue (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire pdq_pkg::in_req_t             in_req,
  output logic                              out_valid,
  output pdq_pkg::out_res_t                 out_result,
  input  wire                               cfg_we,
  input  wire  [pdq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pdq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pdq_pkg::*;

  // configuration
  logic               lag_in_r, lag_out_r, range_en_r;
  logic [DLY_W-1:0]   fixed_r, rmin_r, rmax_r;
  logic [BATCH_W-1:0] batch_r;
  logic [LFSR_W-1:0]  lfsr_r;

  // control
  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, wr_ptr_r, rd_ptr_nxt, wr_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   flush_r, flush_nxt;
  logic               store_r, draw_r;
  logic               out_valid_r;

  // payload
  in_req_t            req_r;
  out_res_t           out_r, out_nxt;
  entry_t             mem [CAPACITY];
  entry_t             mem_q;
  entry_t             wr_entry;

  logic               accept;
  logic               sel_dir, store_now, draw_now;
  logic [DLY_W-1:0]   c_min, c_max, lo, hi, span, delay, rem;
  logic               mod_done;
  mod_req_t           mod_req;
  logic               push, pop;
  kind_t              kind;
  logic [TIME_W-1:0]  age;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // delay range, bounds swapped when reversed
  always_comb begin
    c_min = clamp_delay(rmin_r);
    c_max = clamp_delay(rmax_r);
    lo    = (c_max < c_min) ? c_max : c_min;
    hi    = (c_max < c_min) ? c_min : c_max;
    span  = hi - lo + 1'b1;
  end

  always_comb begin
    sel_dir   = in_req.is_outbound ? lag_out_r : lag_in_r;
    store_now = (in_req.operation == OP_ARRIVE) && sel_dir &&
                (count_r < CNT_W'(CAPACITY));
    draw_now  = store_now && range_en_r && (lo != hi);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (draw_now) begin
            state_nxt = ST_MOD;
          end else if ((in_req.operation == OP_POLL) ||
                       (in_req.operation == OP_CLOSE)) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FETCH:  state_nxt = ST_FINISH;
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mod_req.start    = (state_r == ST_IDLE) && accept && draw_now;
    mod_req.dividend = lfsr_next(lfsr_r);
    mod_req.divisor  = span;
  end

  pdq_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .done  (mod_done),
    .rem   (rem)
  );

  // finish step: push, pop and the result
  always_comb begin
    if (!range_en_r) begin
      delay = clamp_delay(fixed_r);
    end else if (draw_r) begin
      delay = lo + rem;
    end else begin
      delay = lo;
    end
    wr_entry.handle   = req_r.packet_handle;
    wr_entry.outbound = req_r.is_outbound;
    wr_entry.due      = req_r.now_ms + TIME_W'(delay);
    age               = req_r.now_ms - mem_q.due;

    push = 1'b0;
    pop  = 1'b0;
    kind = KIND_NONE;
    if (state_r == ST_FINISH) begin
      case (req_r.operation)
        OP_ARRIVE: begin
          if (store_r) begin
            push = 1'b1;
          end else begin
            kind = KIND_PASS;
          end
        end
        OP_POLL: begin
          if (count_r != '0) begin
            if (flush_r != '0) begin
              pop  = 1'b1;
              kind = KIND_FLUSH;
            end else if (!age[TIME_W-1]) begin
              pop  = 1'b1;
              kind = KIND_DUE;
            end
          end
        end
        OP_CLOSE: begin
          if (count_r != '0) begin
            pop  = 1'b1;
            kind = KIND_DRAIN;
          end
        end
        default: kind = KIND_NONE;
      endcase
    end

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    flush_nxt  = flush_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CAPACITY - 1)) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
      if ((count_nxt == CNT_W'(CAPACITY)) && (flush_r == '0)) begin
        flush_nxt = (batch_r == '0) ? CNT_W'(1) : CNT_W'(batch_r);
      end
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CAPACITY - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
      if (kind == KIND_FLUSH) begin
        flush_nxt = flush_r - 1'b1;
      end
      if (count_nxt == '0) begin
        flush_nxt = '0;
      end
    end

    out_nxt.result_kind     = kind;
    out_nxt.out_handle      = '0;
    out_nxt.out_outbound    = 1'b0;
    if (kind == KIND_PASS) begin
      out_nxt.out_handle   = req_r.packet_handle;
      out_nxt.out_outbound = req_r.is_outbound;
    end else if (pop) begin
      out_nxt.out_handle   = mem_q.handle;
      out_nxt.out_outbound = mem_q.outbound;
    end
    out_nxt.buffer_nonempty = (count_nxt != '0);
    out_nxt.buffer_count    = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      flush_r     <= '0;
      out_valid_r <= 1'b0;
      store_r     <= 1'b0;
      draw_r      <= 1'b0;
      lag_in_r    <= 1'b1;
      lag_out_r   <= 1'b1;
      fixed_r     <= DELAY_DEFAULT;
      range_en_r  <= 1'b0;
      rmin_r      <= DELAY_DEFAULT;
      rmax_r      <= DELAY_DEFAULT;
      batch_r     <= BATCH_DEFAULT;
      lfsr_r      <= SEED_DEFAULT;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= (state_r == ST_FINISH);
      if (accept) begin
        store_r <= store_now;
        draw_r  <= draw_now;
      end
      // step the LFSR only when a random delay is drawn
      if (mod_req.start) begin
        lfsr_r <= mod_req.dividend;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LAG_INBOUND:  lag_in_r   <= cfg_wdata[0];
          REG_LAG_OUTBOUND: lag_out_r  <= cfg_wdata[0];
          REG_FIXED_DELAY:  fixed_r    <= cfg_wdata[DLY_W-1:0];
          REG_RANGE_ENABLE: range_en_r <= cfg_wdata[0];
          REG_RANGE_MIN:    rmin_r     <= cfg_wdata[DLY_W-1:0];
          REG_RANGE_MAX:    rmax_r     <= cfg_wdata[DLY_W-1:0];
          REG_FLUSH_BATCH:  batch_r    <= cfg_wdata[BATCH_W-1:0];
          REG_RANDOM_SEED: begin
            lfsr_r <= (cfg_wdata[LFSR_W-1:0] == '0) ? SEED_DEFAULT
                                                     : cfg_wdata[LFSR_W-1:0];
          end
          default: lag_in_r <= lag_in_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == ST_FINISH) begin
      out_r <= out_nxt;
    end
  end

  // entry store: one write port, one registered read at the head
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
    mem_q <= mem[rd_ptr_r];
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[PTR_W-1:0])
    else $error("pointers disagree with held count");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r != '0) |-> (count_r != '0))
    else $error("flush pending on an empty buffer");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_FINISH))
    else $error("result strobe without a finish step");

  a_mod_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |=> ((state_r == ST_MOD) || (state_r == ST_FINISH)))
    else $error("left remainder wait early");
`endif

endmodule

`default_nettype wire
